// File: rtl/core/thsp_pkg.sv
// ----------------------------------------------------------------------------
// thsp_pkg
// shared types and constants of the terrain height statistics parser
// ----------------------------------------------------------------------------
package thsp_pkg;

	// tile cap and the widths that follow from it
	localparam int MAX_TILES       = 64 * 64;
	localparam int TILE_STRIDE_DEF = 12;
	localparam int CNT_W           = $clog2(MAX_TILES + 1);
	localparam int SUM_W           = 9 + $clog2(MAX_TILES);
	localparam int DVD_W           = SUM_W + 8;
	localparam int AVG_W           = 16;

	localparam logic signed [7:0] HEIGHT_TOP = 8'sd127;
	localparam logic signed [7:0] HEIGHT_BOT = -8'sd128;

	// parse phase of the byte stream
	typedef enum logic [4:0] {
		PH_LEN  = 5'b00001,
		PH_NAME = 5'b00010,
		PH_OX   = 5'b00100,
		PH_OY   = 5'b01000,
		PH_TILE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                    ok;
		logic [CNT_W-1:0]        tiles_counted;
		logic signed [7:0]       low_height;
		logic signed [7:0]       high_height;
		logic signed [AVG_W-1:0] height_avg_q8;
		logic [7:0]              name_length;
		logic [7:0]              origin_x;
		logic [7:0]              origin_y;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic div_start;
		logic load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic res_ok;
		logic div_done;
	} ctl_sts_t;

endpackage

// File: rtl/core/thsp_div.sv
// ----------------------------------------------------------------------------
// thsp_div
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module thsp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [thsp_pkg::DVD_W-1:0]  dividend,
	input  logic [thsp_pkg::CNT_W-1:0]         divisor,
	output logic                               done,
	output logic signed [thsp_pkg::AVG_W-1:0]  quotient
);
	import thsp_pkg::*;

	localparam int IDX_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [IDX_W-1:0] idx_q;
	logic             neg_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W:0]   trial;
	logic             fits;
	logic [DVD_W-1:0] signed_quo;

	// shift in the next dividend bit and try the subtract
	assign trial      = {rem_q, quo_q[DVD_W-1]};
	assign fits       = trial >= {1'b0, den_q};
	assign signed_quo = neg_q ? (~quo_q + DVD_W'(1)) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == IDX_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = signed_quo[AVG_W-1:0];

endmodule

// File: rtl/core/thsp_dp.sv
// ----------------------------------------------------------------------------
// thsp_dp
// byte parser, running height statistics, result staging and output register
// ----------------------------------------------------------------------------
module thsp_dp #(
	parameter int TILE_STRIDE = thsp_pkg::TILE_STRIDE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  thsp_pkg::in_item_t  stream_item,
	input  thsp_pkg::ctl_cmd_t  cmd,
	output thsp_pkg::ctl_sts_t  sts,
	output thsp_pkg::out_item_t result_item
);
	import thsp_pkg::*;

	localparam int POS_W = (TILE_STRIDE > 1) ? $clog2(TILE_STRIDE) : 1;

	// parse state
	phase_t                  phase_q, phase_n;
	logic [7:0]              name_left_q, name_left_n;
	logic [7:0]              name_size_q, name_size_n;
	logic [7:0]              ox_q, ox_n;
	logic [7:0]              oy_q, oy_n;
	logic [POS_W-1:0]        pos_q, pos_n;
	logic signed [7:0]       pend_q, pend_n;
	logic [CNT_W-1:0]        tiles_q, tiles_n;
	logic signed [7:0]       min_q, min_n;
	logic signed [7:0]       max_q, max_n;
	logic signed [SUM_W-1:0] sum_q, sum_n;
	logic signed [7:0]       height;
	logic                    res_ok;

	// staged result while the divider runs
	logic                    stg_ok_q;
	logic [CNT_W-1:0]        stg_cnt_q;
	logic signed [7:0]       stg_min_q;
	logic signed [7:0]       stg_max_q;
	logic [7:0]              stg_len_q;
	logic [7:0]              stg_ox_q;
	logic [7:0]              stg_oy_q;
	out_item_t               result_q;

	logic                    div_done;
	logic signed [AVG_W-1:0] quotient;
	logic signed [DVD_W-1:0] dividend;

	always_comb begin
		phase_n     = phase_q;
		name_left_n = name_left_q;
		name_size_n = name_size_q;
		ox_n        = ox_q;
		oy_n        = oy_q;
		pos_n       = pos_q;
		pend_n      = pend_q;
		tiles_n     = tiles_q;
		min_n       = min_q;
		max_n       = max_q;
		sum_n       = sum_q;
		height      = (pos_q == '0) ? $signed(stream_item.data_byte) : pend_q;
		case (phase_q)
			PH_LEN: begin
				name_size_n = stream_item.data_byte;
				name_left_n = stream_item.data_byte;
				phase_n     = (stream_item.data_byte == 8'd0) ? PH_OX : PH_NAME;
			end
			PH_NAME: begin
				name_left_n = name_left_q - 8'd1;
				if (name_left_q == 8'd1)
					phase_n = PH_OX;
			end
			PH_OX: begin
				ox_n    = stream_item.data_byte;
				phase_n = PH_OY;
			end
			PH_OY: begin
				oy_n    = stream_item.data_byte;
				phase_n = PH_TILE;
				pos_n   = '0;
			end
			PH_TILE: begin
				if (tiles_q < CNT_W'(MAX_TILES)) begin
					if (pos_q == '0)
						pend_n = $signed(stream_item.data_byte);
					if (pos_q == POS_W'(TILE_STRIDE - 1)) begin
						pos_n   = '0;
						tiles_n = tiles_q + CNT_W'(1);
						if (height < min_q)
							min_n = height;
						if (height > max_q)
							max_n = height;
						sum_n = sum_q + SUM_W'(height);
					end else begin
						pos_n = pos_q + POS_W'(1);
					end
				end
			end
			default: phase_n = PH_LEN;
		endcase
	end

	// outcome of the buffer if this byte is its last
	assign res_ok   = (phase_n == PH_TILE) && (tiles_n != '0);
	assign dividend = {sum_n, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			name_left_q <= '0;
			name_size_q <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			pos_q       <= '0;
			pend_q      <= '0;
			tiles_q     <= '0;
			min_q       <= HEIGHT_TOP;
			max_q       <= HEIGHT_BOT;
			sum_q       <= '0;
		end else if (cmd.take) begin
			if (stream_item.last_byte) begin
				phase_q     <= PH_LEN;
				name_left_q <= '0;
				name_size_q <= '0;
				ox_q        <= '0;
				oy_q        <= '0;
				pos_q       <= '0;
				pend_q      <= '0;
				tiles_q     <= '0;
				min_q       <= HEIGHT_TOP;
				max_q       <= HEIGHT_BOT;
				sum_q       <= '0;
			end else begin
				phase_q     <= phase_n;
				name_left_q <= name_left_n;
				name_size_q <= name_size_n;
				ox_q        <= ox_n;
				oy_q        <= oy_n;
				pos_q       <= pos_n;
				pend_q      <= pend_n;
				tiles_q     <= tiles_n;
				min_q       <= min_n;
				max_q       <= max_n;
				sum_q       <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && stream_item.last_byte) begin
			stg_ok_q  <= res_ok;
			stg_cnt_q <= tiles_n;
			stg_min_q <= min_n;
			stg_max_q <= max_n;
			stg_len_q <= name_size_n;
			stg_ox_q  <= ox_n;
			stg_oy_q  <= oy_n;
		end
		if (cmd.load) begin
			if (stg_ok_q) begin
				result_q.ok            <= 1'b1;
				result_q.tiles_counted <= stg_cnt_q;
				result_q.low_height    <= stg_min_q;
				result_q.high_height   <= stg_max_q;
				result_q.height_avg_q8 <= quotient;
				result_q.name_length   <= stg_len_q;
				result_q.origin_x      <= stg_ox_q;
				result_q.origin_y      <= stg_oy_q;
			end else begin
				result_q <= '0;
			end
		end
	end

	thsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (tiles_n),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.res_ok   = res_ok;
	assign sts.div_done = div_done;
	assign result_item  = result_q;

endmodule

// File: rtl/core/thsp_ctrl.sv
// ----------------------------------------------------------------------------
// thsp_ctrl
// sequencing of byte intake, average division and result hand-off
// ----------------------------------------------------------------------------
module thsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stream_valid,
	input  logic               stream_last,
	output logic               stream_ready,
	output logic               result_valid,
	input  logic               result_ready,
	input  thsp_pkg::ctl_sts_t sts,
	output thsp_pkg::ctl_cmd_t cmd
);
	import thsp_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_DIV  = 3'b010,
		ST_LOAD = 3'b100
	} ctl_state_t;

	ctl_state_t state_q, state_n;
	logic       valid_q;
	logic       out_free;

	assign out_free      = !valid_q || result_ready;
	assign stream_ready  = (state_q == ST_RUN);
	assign cmd.take      = stream_ready && stream_valid;
	assign cmd.div_start = cmd.take && stream_last && sts.res_ok;
	assign cmd.load      = (state_q == ST_LOAD) && out_free;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.take && stream_last)
					state_n = sts.res_ok ? ST_DIV : ST_LOAD;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_n = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free)
					state_n = ST_RUN;
			end
			default: state_n = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load)
				valid_q <= 1'b1;
			else if (result_ready)
				valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;

endmodule

// File: rtl/core/terrain_height_stats_parser_top.sv
// ----------------------------------------------------------------------------
// terrain_height_stats_parser_top
// streams a terrain file byte by byte and reports tile height statistics
// ----------------------------------------------------------------------------
// The block takes one byte item per clock while it is parsing: a length byte,
// that many name bytes, an x and a y offset byte, then tiles of TILE_STRIDE
// bytes whose first byte is a signed height. Up to MAX_TILES whole tiles are
// counted; further bytes are swallowed. The item flagged last_byte closes the
// buffer and yields exactly one result item. A failed buffer (header cut short
// or no whole tile) gives ok = 0 with every other field zero, via the load
// state. A good buffer runs a bit-serial divider for the Q8 average, one
// quotient bit per cycle over the 29-bit scaled sum, so stream_ready is low
// from its last byte until the result is loaded. The result sits in an output
// register; once the next buffer starts, bytes flow again even if the earlier
// result has not yet been taken, and a new result only waits for that one.
// ----------------------------------------------------------------------------
module terrain_height_stats_parser_top #(
	parameter int TILE_STRIDE = thsp_pkg::TILE_STRIDE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte stream
	input  logic                stream_valid,
	output logic                stream_ready,
	input  thsp_pkg::in_item_t  stream_item,
	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output thsp_pkg::out_item_t result_item
);
	import thsp_pkg::*;

	// command and status between sequencer and datapath
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer: intake, divide wait, result hand-off
	thsp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_last  (stream_item.last_byte),
		.stream_ready (stream_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// parser, statistics, divider and output register
	thsp_dp #(
		.TILE_STRIDE (TILE_STRIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream_item (stream_item),
		.cmd         (cmd),
		.sts         (sts),
		.result_item (result_item)
	);

endmodule
